>>> src/video_rx_tuner_and_rssi_scan_macros.svh
// Assertion macros shared by the tuner and RSSI scan RTL.
`ifndef VIDEO_RX_TUNER_AND_RSSI_SCAN_MACROS_SVH
`define VIDEO_RX_TUNER_AND_RSSI_SCAN_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define VRTS_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vrts assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define VRTS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vrts assertion failed");

`endif

>>> src/vrts_pkg.sv
// Types, constants and helper functions of the tuner and RSSI scan block.
`default_nettype none

package vrts_pkg;

    localparam int FREQ_W      = 13;
    localparam int RSSI_W      = 10;
    localparam int SETTLE_W    = 10;
    localparam int ELAPSED_W   = 11;
    localparam int FRAME_LEN   = 25;
    localparam int IDX_W       = 5;
    localparam int DATA_BITS   = 16;
    localparam int WORD_W      = 20;
    localparam int SAMPLE_COUNT = 20;

    localparam int CNT_W       = $clog2(SAMPLE_COUNT + 1);
    localparam int SUM_W       = $clog2(SAMPLE_COUNT * 1023 + 1);

    // floor(sum / SAMPLE_COUNT) as (sum * DIV_RECIP) >> DIV_SHIFT, exact over SUM_W bits
    localparam int DIV_LOG     = $clog2(SAMPLE_COUNT);
    localparam int DIV_SHIFT   = SUM_W + DIV_LOG;
    localparam int RECIP_W     = DIV_SHIFT - DIV_LOG + 1;
    localparam logic [RECIP_W-1:0] DIV_RECIP =
        RECIP_W'((2 ** DIV_SHIFT + SAMPLE_COUNT - 1) / SAMPLE_COUNT);

    localparam int CMD_DEPTH   = 4;
    localparam int PTR_W       = $clog2(CMD_DEPTH);

    localparam logic [FREQ_W-1:0]    MIN_FREQ    = FREQ_W'(479);
    localparam logic [SETTLE_W-1:0]  SETTLE_RST  = SETTLE_W'(75);
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
    localparam logic [IDX_W-1:0]     LAST_IDX    = IDX_W'(FRAME_LEN - 1);

    localparam logic [1:0] OP_TUNE   = 2'd0;
    localparam logic [1:0] OP_SCAN   = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_SAMPLE = 2'd3;

    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_RSSI  = 1'b1;

    // One queued job for the back end: a frame to shift out or a sum to average.
    typedef struct packed {
        logic                 kind;
        logic [DATA_BITS-1:0] word;
        logic [SUM_W-1:0]     sum;
    } t_cmd;

    // Synthesizer word: r = (f - 479) / 2, word = ((r / 32) << 7) + (r % 32)
    function automatic logic [DATA_BITS-1:0] synth_word(input logic [FREQ_W-1:0] freq);
        logic [FREQ_W-1:0] fc;
        logic [FREQ_W-1:0] diff;
        logic [WORD_W-1:0] w;
        fc   = (freq < MIN_FREQ) ? MIN_FREQ : freq;
        diff = fc - MIN_FREQ;
        w    = {6'd0, diff[12:6], 2'b00, diff[5:1]};
        return w[DATA_BITS-1:0];
    endfunction

    // Frame bit i at position i: address 0x1, write bit, data LSB first, zero pad
    function automatic logic [FRAME_LEN-1:0] make_frame(input logic [DATA_BITS-1:0] word);
        logic [FRAME_LEN-1:0] fr;
        fr = '0;
        fr[0] = 1'b1;
        fr[4] = 1'b1;
        fr[5 +: DATA_BITS] = word;
        return fr;
    endfunction

endpackage

`default_nettype wire

>>> src/video_rx_tuner_and_rssi_scan.sv
// Top level of the video receiver tuner and RSSI scan block.
`default_nettype none

// Tunes a 5.8 GHz video receiver synthesizer and averages RSSI readings.
// Input transactions (push/full) carry an operation: tune now, start scan,
// one-millisecond tick, or RSSI sample. A tune, and the first tick after a
// scan start, turns the frequency into the synthesizer word
// r = (f - 479) / 2, word = ((r / 32) << 7) + (r % 32) and produces a 25-bit
// write frame as 25 result transactions, one bit each: address 0x1 LSB first,
// a write bit of 1, 16 data bits LSB first, four zeros; the last bit has
// o_last set. Once more than settle_ms ticks have passed since the scan tune,
// twenty samples are summed and one result with o_kind set carries the
// truncated mean. Results come out of a queue interface (empty/pop).
// Timing: an input transaction is taken whenever the job queue (four entries)
// has room. The back end sends one result per cycle while pop stays high and
// ends each frame before it pops the next job, so that serializer sets the
// sustained rate of tunes. Ticks, scan starts and samples that produce no
// result only occupy the front end. The first result goes through the job
// queue, then the output register. settle_ms resets to 75; the user must write
// it through i_cfg_we/i_cfg_wdata while the block is idle; not enforced.
module video_rx_tuner_and_rssi_scan (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_push,
    output logic                                 o_full,
    input  wire logic [1:0]                      i_operation,
    input  wire logic [vrts_pkg::FREQ_W-1:0]     i_frequency_mhz,
    input  wire logic [vrts_pkg::RSSI_W-1:0]     i_rssi_sample,
    input  wire logic                            i_cfg_we,
    input  wire logic [vrts_pkg::SETTLE_W-1:0]   i_cfg_wdata,
    output logic                                 o_empty,
    input  wire logic                            i_pop,
    output logic                                 o_kind,
    output logic                                 o_serial_data,
    output logic [vrts_pkg::IDX_W-1:0]           o_bit_index,
    output logic [vrts_pkg::RSSI_W-1:0]          o_rssi_average,
    output logic                                 o_last
);

    logic            cmd_push;
    vrts_pkg::t_cmd  cmd_in;
    vrts_pkg::t_cmd  cmd_out;
    logic            q_full;
    logic            q_empty;
    logic            q_pop;

    // Input side backs up only when the job queue is full.
    assign o_full = q_full;

    vrts_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (i_push),
        .i_q_full        (q_full),
        .i_operation     (i_operation),
        .i_frequency_mhz (i_frequency_mhz),
        .i_rssi_sample   (i_rssi_sample),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_cmd_push      (cmd_push),
        .o_cmd           (cmd_in)
    );

    // Decouples classification from the bit-serial output.
    vrts_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (cmd_out),
        .o_empty (q_empty)
    );

    // Serializer plus output register; the register lets the queue refill
    // while a result waits to be popped.
    vrts_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd_out),
        .i_q_empty      (q_empty),
        .o_q_pop        (q_pop),
        .i_pop          (i_pop),
        .o_empty        (o_empty),
        .o_kind         (o_kind),
        .o_serial_data  (o_serial_data),
        .o_bit_index    (o_bit_index),
        .o_rssi_average (o_rssi_average),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

>>> src/vrts_front.sv
// Front end: takes input transactions, runs the scan state and queues back-end jobs.
`default_nettype none

module vrts_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_push,
    input  wire logic                            i_q_full,
    input  wire logic [1:0]                      i_operation,
    input  wire logic [vrts_pkg::FREQ_W-1:0]     i_frequency_mhz,
    input  wire logic [vrts_pkg::RSSI_W-1:0]     i_rssi_sample,
    input  wire logic                            i_cfg_we,
    input  wire logic [vrts_pkg::SETTLE_W-1:0]   i_cfg_wdata,
    output logic                                 o_cmd_push,
    output vrts_pkg::t_cmd                       o_cmd
);

    localparam logic [1:0] PHASE_DONE = 2'd0;
    localparam logic [1:0] PHASE_SET  = 2'd1;
    localparam logic [1:0] PHASE_SCAN = 2'd2;

    logic [1:0]                       r_phase,   n_phase;
    logic [vrts_pkg::FREQ_W-1:0]      r_freq,    n_freq;
    logic [vrts_pkg::ELAPSED_W-1:0]   r_elapsed, n_elapsed;
    logic [vrts_pkg::SUM_W-1:0]       r_sum,     n_sum;
    logic [vrts_pkg::CNT_W-1:0]       r_taken,   n_taken;
    logic [vrts_pkg::SETTLE_W-1:0]    r_settle,  n_settle;

    logic                             accept;
    logic [vrts_pkg::SUM_W-1:0]       sum_nx;
    logic [vrts_pkg::CNT_W-1:0]       taken_nx;

    assign accept   = i_push && !i_q_full;
    assign sum_nx   = r_sum + vrts_pkg::SUM_W'(i_rssi_sample);
    assign taken_nx = r_taken + vrts_pkg::CNT_W'(1);

    always_comb begin
        n_phase    = r_phase;
        n_freq     = r_freq;
        n_elapsed  = r_elapsed;
        n_sum      = r_sum;
        n_taken    = r_taken;
        n_settle   = i_cfg_we ? i_cfg_wdata : r_settle;
        o_cmd_push = 1'b0;
        o_cmd.kind = vrts_pkg::KIND_FRAME;
        o_cmd.word = vrts_pkg::synth_word(i_frequency_mhz);
        o_cmd.sum  = sum_nx;
        if (accept) begin
            case (i_operation)
                vrts_pkg::OP_TUNE: begin
                    o_cmd_push = 1'b1;
                end
                vrts_pkg::OP_SCAN: begin
                    n_freq    = i_frequency_mhz;
                    n_phase   = PHASE_SET;
                    n_elapsed = '0;
                    n_sum     = '0;
                    n_taken   = '0;
                end
                vrts_pkg::OP_TICK: begin
                    if (r_phase == PHASE_SET) begin
                        // first tick after a scan start tunes the stored channel
                        n_phase    = PHASE_SCAN;
                        n_elapsed  = '0;
                        n_sum      = '0;
                        n_taken    = '0;
                        o_cmd_push = 1'b1;
                        o_cmd.word = vrts_pkg::synth_word(r_freq);
                    end else if (r_phase == PHASE_SCAN && r_elapsed != vrts_pkg::ELAPSED_MAX) begin
                        n_elapsed = r_elapsed + vrts_pkg::ELAPSED_W'(1);
                    end
                end
                vrts_pkg::OP_SAMPLE: begin
                    if (r_phase == PHASE_SCAN &&
                        r_elapsed > vrts_pkg::ELAPSED_W'(r_settle)) begin
                        if (taken_nx == vrts_pkg::CNT_W'(vrts_pkg::SAMPLE_COUNT)) begin
                            o_cmd_push = 1'b1;
                            o_cmd.kind = vrts_pkg::KIND_RSSI;
                            n_phase    = PHASE_DONE;
                            n_sum      = '0;
                            n_taken    = '0;
                        end else begin
                            n_sum   = sum_nx;
                            n_taken = taken_nx;
                        end
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PHASE_DONE;
            r_freq    <= '0;
            r_elapsed <= '0;
            r_sum     <= '0;
            r_taken   <= '0;
            r_settle  <= vrts_pkg::SETTLE_RST;
        end else begin
            r_phase   <= n_phase;
            r_freq    <= n_freq;
            r_elapsed <= n_elapsed;
            r_sum     <= n_sum;
            r_taken   <= n_taken;
            r_settle  <= n_settle;
        end
    end

endmodule

`default_nettype wire

>>> src/vrts_cmd_fifo.sv
// Short job queue between the front end and the back end.
`default_nettype none

`include "video_rx_tuner_and_rssi_scan_macros.svh"

module vrts_cmd_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire vrts_pkg::t_cmd  i_cmd,
    output logic                 o_full,
    input  wire logic            i_pop,
    output vrts_pkg::t_cmd       o_cmd,
    output logic                 o_empty
);

    vrts_pkg::t_cmd                  r_mem [vrts_pkg::CMD_DEPTH];
    logic [vrts_pkg::PTR_W-1:0]      r_wr, n_wr;
    logic [vrts_pkg::PTR_W-1:0]      r_rd, n_rd;
    logic [vrts_pkg::PTR_W:0]        r_count, n_count;

    assign o_full  = (r_count == (vrts_pkg::PTR_W+1)'(vrts_pkg::CMD_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd];

    always_comb begin
        n_wr    = i_push ? r_wr + vrts_pkg::PTR_W'(1) : r_wr;
        n_rd    = i_pop  ? r_rd + vrts_pkg::PTR_W'(1) : r_rd;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + (vrts_pkg::PTR_W+1)'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - (vrts_pkg::PTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    `VRTS_ASSERT_IMPL(a_count_range, 1'b1, r_count <= (vrts_pkg::PTR_W+1)'(vrts_pkg::CMD_DEPTH))
    `VRTS_ASSERT_IMPL(a_no_pop_empty, i_pop, !o_empty)
    `VRTS_ASSERT_IMPL(a_no_push_full, i_push, !o_full)

endmodule

`default_nettype wire

>>> src/vrts_back.sv
// Back end: shifts out tune frames bit by bit and finishes RSSI averages.
`default_nettype none

`include "video_rx_tuner_and_rssi_scan_macros.svh"

module vrts_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire vrts_pkg::t_cmd                  i_cmd,
    input  wire logic                            i_q_empty,
    output logic                                 o_q_pop,
    input  wire logic                            i_pop,
    output logic                                 o_empty,
    output logic                                 o_kind,
    output logic                                 o_serial_data,
    output logic [vrts_pkg::IDX_W-1:0]           o_bit_index,
    output logic [vrts_pkg::RSSI_W-1:0]          o_rssi_average,
    output logic                                 o_last
);

    localparam int PROD_W = vrts_pkg::SUM_W + vrts_pkg::RECIP_W;

    logic                              r_busy,  n_busy;
    logic [vrts_pkg::IDX_W-1:0]        r_idx,   n_idx;
    logic [vrts_pkg::FRAME_LEN-1:0]    r_frame, n_frame;

    logic                              r_out_valid, n_out_valid;
    logic                              r_out_kind,  n_out_kind;
    logic                              r_out_data,  n_out_data;
    logic [vrts_pkg::IDX_W-1:0]        r_out_idx,   n_out_idx;
    logic [vrts_pkg::RSSI_W-1:0]       r_out_avg,   n_out_avg;
    logic                              r_out_last,  n_out_last;

    logic                              adv;
    logic [vrts_pkg::FRAME_LEN-1:0]    new_frame;
    logic [PROD_W-1:0]                 prod;

    assign adv       = !r_out_valid || i_pop;
    assign o_q_pop   = adv && !r_busy && !i_q_empty;
    assign new_frame = vrts_pkg::make_frame(i_cmd.word);
    // sum / SAMPLE_COUNT by reciprocal multiply
    assign prod      = PROD_W'(i_cmd.sum) * PROD_W'(vrts_pkg::DIV_RECIP);

    always_comb begin
        n_busy      = r_busy;
        n_idx       = r_idx;
        n_frame     = r_frame;
        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_data  = r_out_data;
        n_out_idx   = r_out_idx;
        n_out_avg   = r_out_avg;
        n_out_last  = r_out_last;
        if (adv) begin
            n_out_valid = 1'b0;
            if (r_busy) begin
                n_out_valid = 1'b1;
                n_out_kind  = vrts_pkg::KIND_FRAME;
                n_out_data  = r_frame[r_idx];
                n_out_idx   = r_idx;
                n_out_avg   = '0;
                n_out_last  = (r_idx == vrts_pkg::LAST_IDX);
                n_busy      = (r_idx != vrts_pkg::LAST_IDX);
                n_idx       = r_idx + vrts_pkg::IDX_W'(1);
            end else if (!i_q_empty) begin
                n_out_valid = 1'b1;
                if (i_cmd.kind == vrts_pkg::KIND_FRAME) begin
                    // bit 0 goes out straight from the queue head
                    n_out_kind = vrts_pkg::KIND_FRAME;
                    n_out_data = new_frame[0];
                    n_out_idx  = '0;
                    n_out_avg  = '0;
                    n_out_last = 1'b0;
                    n_frame    = new_frame;
                    n_busy     = 1'b1;
                    n_idx      = vrts_pkg::IDX_W'(1);
                end else begin
                    n_out_kind = vrts_pkg::KIND_RSSI;
                    n_out_data = 1'b0;
                    n_out_idx  = '0;
                    n_out_avg  = prod[vrts_pkg::DIV_SHIFT +: vrts_pkg::RSSI_W];
                    n_out_last = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame    <= n_frame;
        r_out_kind <= n_out_kind;
        r_out_data <= n_out_data;
        r_out_idx  <= n_out_idx;
        r_out_avg  <= n_out_avg;
        r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_kind         = r_out_kind;
    assign o_serial_data  = r_out_data;
    assign o_bit_index    = r_out_idx;
    assign o_rssi_average = r_out_avg;
    assign o_last         = r_out_last;

    `VRTS_ASSERT_IMPL(a_busy_idx, r_busy, r_idx != '0)
    `VRTS_ASSERT_NEXT(a_frame_end, adv && r_busy && r_idx == vrts_pkg::LAST_IDX, !r_busy)
    `VRTS_ASSERT_IMPL(a_rssi_last, r_out_valid && r_out_kind == vrts_pkg::KIND_RSSI, r_out_last && r_out_idx == '0)

endmodule

`default_nettype wire

>>> tb/tuner_scan_checker.sv
// Checker for the tuner and RSSI scan block: predicts every result and compares.
module tuner_scan_checker
    import vrts_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire logic                i_full,
    input  wire logic [1:0]          i_operation,
    input  wire logic [FREQ_W-1:0]   i_frequency_mhz,
    input  wire logic [RSSI_W-1:0]   i_rssi_sample,
    input  wire logic                i_cfg_we,
    input  wire logic [SETTLE_W-1:0] i_cfg_wdata,
    input  wire logic                i_empty,
    input  wire logic                i_pop,
    input  wire logic                i_kind,
    input  wire logic                i_serial_data,
    input  wire logic [IDX_W-1:0]    i_bit_index,
    input  wire logic [RSSI_W-1:0]   i_rssi_average,
    input  wire logic                i_last,
    output int                       o_mismatches,
    output int                       o_pending
);

    typedef enum logic [1:0] {SCAN_IDLE, SCAN_ARMED, SCAN_RUN} t_scan_state;

    typedef struct packed {
        logic              kind;
        logic              serial_data;
        logic [IDX_W-1:0]  bit_index;
        logic [RSSI_W-1:0] rssi_average;
        logic              last;
    } t_rx_result;

    t_scan_state          scan_mode;
    logic [FREQ_W-1:0]    scan_freq;
    logic [ELAPSED_W-1:0] ticks_since_tune;
    logic [SETTLE_W-1:0]  settle_copy;
    int unsigned          rssi_acc;
    int unsigned          rssi_count;
    t_rx_result           bits_and_rssi_q[$];
    t_rx_result           got;
    t_rx_result           want;
    int                   mismatch_count = 0;

    initial o_pending = 0;
    assign o_mismatches = mismatch_count;

    // Synthesizer word: clamp to 479 MHz, halve the offset, 5 low bits stay, rest moves up to bit 7
    function automatic logic [DATA_BITS-1:0] channel_word(input logic [FREQ_W-1:0] freq);
        int unsigned f;
        int unsigned r;
        f = (freq < MIN_FREQ) ? MIN_FREQ : freq;
        r = (f - MIN_FREQ) / 2;
        return DATA_BITS'(((r / 32) << 7) + (r % 32));
    endfunction

    // Address 1 LSB first, write bit, data word LSB first, zero pad to 25 bits
    task automatic queue_frame(input logic [DATA_BITS-1:0] word);
        t_rx_result r;
        for (int i = 0; i < FRAME_LEN; i++) begin
            r = '0;
            r.kind = KIND_FRAME;
            if (i == 0 || i == 4)
                r.serial_data = 1'b1;
            else if (i >= 5 && i < 5 + DATA_BITS)
                r.serial_data = word[i - 5];
            r.bit_index = IDX_W'(i);
            r.last = (i == FRAME_LEN - 1);
            bits_and_rssi_q.push_back(r);
        end
    endtask

    task automatic predict_item(input logic [1:0] op, input logic [FREQ_W-1:0] freq,
                                input logic [RSSI_W-1:0] sample);
        t_rx_result r;
        case (op)
            OP_TUNE: queue_frame(channel_word(freq));
            OP_SCAN: begin
                scan_freq = freq;
                scan_mode = SCAN_ARMED;
                ticks_since_tune = '0;
                rssi_acc = 0;
                rssi_count = 0;
            end
            OP_TICK: begin
                if (scan_mode == SCAN_ARMED) begin
                    scan_mode = SCAN_RUN;
                    ticks_since_tune = '0;
                    rssi_acc = 0;
                    rssi_count = 0;
                    queue_frame(channel_word(scan_freq));
                end else if (scan_mode == SCAN_RUN && ticks_since_tune != ELAPSED_MAX) begin
                    ticks_since_tune = ticks_since_tune + 1'b1;
                end
            end
            OP_SAMPLE: begin
                // samples count only once the settle time has strictly passed
                if (scan_mode == SCAN_RUN && ticks_since_tune > settle_copy) begin
                    rssi_acc += sample;
                    rssi_count++;
                    if (rssi_count == SAMPLE_COUNT) begin
                        r = '0;
                        r.kind = KIND_RSSI;
                        r.rssi_average = RSSI_W'(rssi_acc / SAMPLE_COUNT);
                        r.last = 1'b1;
                        bits_and_rssi_q.push_back(r);
                        scan_mode = SCAN_IDLE;
                        rssi_acc = 0;
                        rssi_count = 0;
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scan_mode = SCAN_IDLE;
            scan_freq = '0;
            ticks_since_tune = '0;
            settle_copy = SETTLE_RST;
            rssi_acc = 0;
            rssi_count = 0;
            bits_and_rssi_q.delete();
        end else begin
            // result side first: a transaction accepted this edge cannot show up yet
            if (i_pop && !i_empty) begin
                got = {i_kind, i_serial_data, i_bit_index, i_rssi_average, i_last};
                if (bits_and_rssi_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with nothing expected: kind=%0d data=%0d idx=%0d avg=%0d last=%0d",
                             $time, got.kind, got.serial_data, got.bit_index,
                             got.rssi_average, got.last);
                end else begin
                    want = bits_and_rssi_q.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        $display("%0t: mismatch expected kind=%0d data=%0d idx=%0d avg=%0d last=%0d, actual kind=%0d data=%0d idx=%0d avg=%0d last=%0d",
                                 $time, want.kind, want.serial_data, want.bit_index,
                                 want.rssi_average, want.last, got.kind, got.serial_data,
                                 got.bit_index, got.rssi_average, got.last);
                    end
                end
            end
            if (i_cfg_we)
                settle_copy = i_cfg_wdata;
            if (i_push && !i_full)
                predict_item(i_operation, i_frequency_mhz, i_rssi_sample);
        end
        o_pending <= bits_and_rssi_q.size();
    end

endmodule

>>> tb/tb_video_rx_tuner_and_rssi_scan.sv
// Testbench top for the tuner and RSSI scan block: stimulus, flow control and verdict.
module tb_video_rx_tuner_and_rssi_scan;
    import vrts_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;     // margin for the job queue and the output register to drain
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off, fills the job queue
    localparam int RANDOM_ITEMS = 20;

    // Sample styles for one scan
    localparam int RSSI_ANY  = 0;
    localparam int RSSI_TOP  = 1;
    localparam int RSSI_ZERO = 2;
    localparam int RSSI_LOW  = 3;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_push = 1'b0;
    logic [1:0]          i_operation = OP_TUNE;
    logic [FREQ_W-1:0]   i_frequency_mhz = '0;
    logic [RSSI_W-1:0]   i_rssi_sample = '0;
    logic                i_cfg_we = 1'b0;
    logic [SETTLE_W-1:0] i_cfg_wdata = '0;
    logic                i_pop = 1'b0;

    logic                o_full;
    logic                o_empty;
    logic                o_kind;
    logic                o_serial_data;
    logic [IDX_W-1:0]    o_bit_index;
    logic [RSSI_W-1:0]   o_rssi_average;
    logic                o_last;

    int mismatches;
    int pending;

    // Sender state
    int                  burst_left = 0;
    bit                  steady = 1'b0;        // no gaps between transactions
    logic [SETTLE_W-1:0] cur_settle = SETTLE_RST;
    int                  items_sent = 0;

    // Receiver state
    logic hold_req = 1'b0;
    bit   hold_taken = 1'b0;
    int   hold_left = 0;
    int   pop_mode = 0;
    int   mode_left = 0;

    int cycle_count = 0;

    always #1 i_clk = ~i_clk;

    video_rx_tuner_and_rssi_scan dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_operation    (i_operation),
        .i_frequency_mhz(i_frequency_mhz),
        .i_rssi_sample  (i_rssi_sample),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_kind         (o_kind),
        .o_serial_data  (o_serial_data),
        .o_bit_index    (o_bit_index),
        .o_rssi_average (o_rssi_average),
        .o_last         (o_last)
    );

    // Watches both channels and the register port, predicts and compares
    tuner_scan_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .i_full         (o_full),
        .i_operation    (i_operation),
        .i_frequency_mhz(i_frequency_mhz),
        .i_rssi_sample  (i_rssi_sample),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_empty        (o_empty),
        .i_pop          (i_pop),
        .i_kind         (o_kind),
        .i_serial_data  (o_serial_data),
        .i_bit_index    (o_bit_index),
        .i_rssi_average (o_rssi_average),
        .i_last         (o_last),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    // Run-away guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: pop pattern changes between always-ready, coin-flip and
    // mostly-stalled stretches. One long hold-off is taken when the stimulus
    // asks for it; it is counted here so the sender keeps pushing meanwhile.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else if (hold_left != 0) begin
            i_pop <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_taken) begin
            i_pop <= 1'b0;
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else begin
            if (mode_left == 0) begin
                pop_mode <= $urandom_range(0, 2);
                mode_left <= $urandom_range(10, 80);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (pop_mode)
                0: i_pop <= 1'b1;
                1: i_pop <= ($urandom_range(0, 1) == 1);
                default: i_pop <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    function automatic logic [RSSI_W-1:0] pick_rssi(input int style);
        case (style)
            RSSI_TOP: return '1;
            RSSI_ZERO: return '0;
            RSSI_LOW: return RSSI_W'($urandom_range(0, 15));
            default: return RSSI_W'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic logic [FREQ_W-1:0] any_freq();
        return FREQ_W'($urandom_range(0, 8191));
    endfunction

    // One input transaction. Bursts of random length with random gaps between
    // them, unless steady is set. Returns right after the accepting edge, so
    // a following call raises nothing that was just lowered.
    task automatic send_item(input logic [1:0] op, input logic [FREQ_W-1:0] freq,
                             input logic [RSSI_W-1:0] rssi);
        if (!steady && burst_left == 0) begin
            i_push <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                                     : $urandom_range(1, 6);
        end
        if (burst_left > 0)
            burst_left--;
        i_push <= 1'b1;
        i_operation <= op;
        i_frequency_mhz <= freq;
        i_rssi_sample <= rssi;
        do @(posedge i_clk); while (o_full);
        items_sent++;
    endtask

    // Stop sending until every expected result is out, then let ticks or
    // samples still in flight pass through the block.
    task automatic settle_down();
        i_push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_settle(input logic [SETTLE_W-1:0] value);
        settle_down();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        cur_settle = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // A well-formed scan: start, tune tick, enough ticks to pass the settle
    // time (plus extra), then the samples. Early samples and stray tunes are
    // mixed in; a broken scan stops short of the last sample.
    task automatic scan_run(input int extra, input bit broken, input int style);
        int ticks;
        int n;
        ticks = int'(cur_settle) + 2 + extra;
        n = broken ? $urandom_range(0, SAMPLE_COUNT - 1) : SAMPLE_COUNT;
        send_item(OP_SCAN, any_freq(), pick_rssi(RSSI_ANY));
        for (int i = 0; i < ticks; i++) begin
            send_item(OP_TICK, any_freq(), pick_rssi(RSSI_ANY));
            // still inside the settle time, so this sample must be dropped
            if (i <= int'(cur_settle) && $urandom_range(0, 7) == 0)
                send_item(OP_SAMPLE, any_freq(), pick_rssi(RSSI_ANY));
            else if ($urandom_range(0, 15) == 0)
                send_item(OP_TUNE, any_freq(), pick_rssi(RSSI_ANY));
        end
        for (int k = 0; k < n; k++) begin
            send_item(OP_SAMPLE, any_freq(), pick_rssi(style));
            if ($urandom_range(0, 9) == 0)
                send_item(OP_TICK, any_freq(), pick_rssi(RSSI_ANY));
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: tune extremes, below-range clamp, ignored tick and sample
        // while idle, tune and restart during a scan, early samples.
        send_item(OP_TUNE, FREQ_W'(0), RSSI_W'(0));
        send_item(OP_TUNE, MIN_FREQ, RSSI_W'(1023));
        send_item(OP_TUNE, FREQ_W'(480), RSSI_W'(0));
        send_item(OP_TUNE, FREQ_W'(8191), RSSI_W'(1023));
        send_item(OP_TUNE, FREQ_W'(5865), RSSI_W'(341));
        send_item(OP_TUNE, FREQ_W'(13'h0AAA), RSSI_W'(682));
        send_item(OP_TICK, FREQ_W'(8191), RSSI_W'(1023));
        send_item(OP_SAMPLE, FREQ_W'(0), RSSI_W'(1023));
        send_item(OP_SCAN, FREQ_W'(5740), RSSI_W'(0));
        send_item(OP_SAMPLE, FREQ_W'(0), RSSI_W'(512));
        send_item(OP_TICK, FREQ_W'(0), RSSI_W'(0));
        send_item(OP_SAMPLE, FREQ_W'(0), RSSI_W'(0));
        send_item(OP_TUNE, FREQ_W'(5905), RSSI_W'(0));
        send_item(OP_TICK, FREQ_W'(0), RSSI_W'(0));
        send_item(OP_SCAN, FREQ_W'(13'h1555), RSSI_W'(1023));
        send_item(OP_TICK, FREQ_W'(13'h1FFF), RSSI_W'(0));
        send_item(OP_TICK, FREQ_W'(0), RSSI_W'(0));
        send_item(OP_SAMPLE, FREQ_W'(8191), RSSI_W'(1023));

        // Receiver holds off for a long stretch while tunes keep coming
        hold_req <= 1'b1;
        steady = 1'b1;
        repeat (10) send_item(OP_TUNE, any_freq(), pick_rssi(RSSI_ANY));
        steady = 1'b0;

        // Zero settle time: first tick after the tune already opens sampling
        write_settle('0);
        scan_run(0, 1'b0, RSSI_TOP);
        scan_run(1, 1'b1, RSSI_ANY);
        scan_run(0, 1'b0, RSSI_ZERO);

        // Random part: mostly complete scans with random content, some broken
        // ones and loose transactions of any kind, short settle times.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0)
                write_settle(SETTLE_W'($urandom_range(1, 6)));
            case ($urandom_range(0, 3))
                0: repeat ($urandom_range(1, 4))
                    send_item(2'($urandom_range(OP_TUNE, OP_SAMPLE)), any_freq(),
                              pick_rssi(RSSI_ANY));
                1: scan_run($urandom_range(0, 3), 1'b1, $urandom_range(RSSI_ANY, RSSI_LOW));
                default: scan_run($urandom_range(0, 3), 1'b0,
                                  $urandom_range(RSSI_ANY, RSSI_LOW));
            endcase
        end

        settle_down();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
